FILE: design/rne_pkg.sv
// Shared types, constants and helper functions of the Roman numeral encoder.
package rne_pkg;

    localparam int VALUE_W = 12;
    localparam int CHAR_W = 8;
    localparam int DIGIT_W = 4;
    localparam int NUM_POS = 4;
    localparam int POS_W = $clog2(NUM_POS);
    localparam int BPOS_W = $clog2(NUM_POS + 1);
    localparam int LEN_W = 3;
    localparam int IDX_W = 2;
    localparam int THR_W = 14;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd3999;

    localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_D = 8'h44;
    localparam logic [CHAR_W-1:0] CH_C = 8'h43;
    localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_V = 8'h56;
    localparam logic [CHAR_W-1:0] CH_I = 8'h49;

    // Digit 0 holds thousands, digit 3 holds ones.
    typedef logic [NUM_POS-1:0][DIGIT_W-1:0] t_digits;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SPLIT,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } t_sym;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [VALUE_W-1:0] rem;
    } t_split;

    function automatic logic [THR_W-1:0] pos_weight(input logic [POS_W-1:0] pos);
        logic [THR_W-1:0] w;
        unique case (pos)
            2'd0: w = 14'd1000;
            2'd1: w = 14'd100;
            2'd2: w = 14'd10;
            2'd3: w = 14'd1;
        endcase
        return w;
    endfunction

    // One decimal digit by parallel compares against its nine multiples.
    function automatic t_split split_digit(input logic [VALUE_W-1:0] rem,
                                           input logic [POS_W-1:0] pos);
        t_split res;
        logic [THR_W-1:0] w;
        logic [THR_W-1:0] thr;
        logic [THR_W-1:0] sub;
        w = pos_weight(pos);
        res.digit = '0;
        sub = '0;
        for (int k = 1; k <= 9; k++) begin
            thr = THR_W'(k) * w;
            if (THR_W'(rem) >= thr) begin
                res.digit = DIGIT_W'(k);
                sub = thr;
            end
        end
        res.rem = VALUE_W'(THR_W'(rem) - sub);
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] n;
        unique case (d)
            4'd1, 4'd5: n = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
            4'd3, 4'd7: n = 3'd3;
            4'd8: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic t_sym digit_sym(input logic [DIGIT_W-1:0] d,
                                       input logic [IDX_W-1:0] idx);
        t_sym s;
        unique case (d)
            4'd4: s = (idx == '0) ? SYM_ONE : SYM_FIVE;
            4'd5: s = SYM_FIVE;
            4'd6, 4'd7, 4'd8: s = (idx == '0) ? SYM_FIVE : SYM_ONE;
            4'd9: s = (idx == '0) ? SYM_ONE : SYM_TEN;
            default: s = SYM_ONE;
        endcase
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] sym_char(input logic [POS_W-1:0] pos,
                                                   input t_sym s);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            2'd0: c = CH_M;
            2'd1: c = (s == SYM_ONE) ? CH_C : ((s == SYM_FIVE) ? CH_D : CH_M);
            2'd2: c = (s == SYM_ONE) ? CH_X : ((s == SYM_FIVE) ? CH_L : CH_C);
            2'd3: c = (s == SYM_ONE) ? CH_I : ((s == SYM_FIVE) ? CH_V : CH_X);
        endcase
        return c;
    endfunction

endpackage

FILE: design/rne_front.sv
// Front end: accepts a value, clamps it and splits it into decimal digits.
module rne_front import rne_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_q_wr,
    output t_digits            o_q_data,
    input  logic               i_q_full
);

    t_fstate            r_state;
    t_fstate            n_state;
    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] n_rem;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    t_digits            r_digits;
    t_digits            n_digits;
    t_split             step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_pos <= n_pos;
        r_digits <= n_digits;
    end

    always_comb begin
        n_state = r_state;
        n_rem = r_rem;
        n_pos = r_pos;
        n_digits = r_digits;
        full = 1'b1;
        o_q_wr = 1'b0;
        step = split_digit(r_rem, r_pos);
        unique case (r_state)
            F_IDLE: begin
                full = 1'b0;
                if (push) begin
                    n_rem = (i_value > VALUE_LIMIT) ? VALUE_LIMIT : i_value;
                    n_pos = '0;
                    n_state = F_SPLIT;
                end
            end
            F_SPLIT: begin
                n_digits[r_pos] = step.digit;
                n_rem = step.rem;
                n_pos = r_pos + 1'b1;
                if (r_pos == POS_W'(NUM_POS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_wr = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_q_data = r_digits;

endmodule

FILE: design/rne_fifo.sv
// Short queue of digit words between the front end and the back end.
module rne_fifo import rne_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_digits i_wdata,
    output logic    o_full,
    input  logic    i_rd,
    output t_digits o_rdata,
    output logic    o_empty
);

    t_digits         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_count;
    logic            do_wr;
    logic            do_rd;

    assign o_full = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

FILE: design/rne_back.sv
// Back end: walks the digits of one value and emits one character per transfer.
module rne_back import rne_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_digits           i_q_data,
    input  logic              i_q_empty,
    output logic              o_q_rd,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last
);

    logic              r_busy;
    logic              n_busy;
    t_digits           r_digits;
    t_digits           n_digits;
    logic [BPOS_W-1:0] r_pos;
    logic [BPOS_W-1:0] n_pos;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;
    logic              r_last;
    logic              n_last;
    logic              adv;
    logic              found;
    logic [POS_W-1:0]  sel;
    logic [DIGIT_W-1:0] sel_digit;
    logic [LEN_W-1:0]  sel_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_pos <= n_pos;
        r_idx <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    // The first digit at or after the current one that still writes letters.
    always_comb begin
        found = 1'b0;
        sel = '0;
        for (int p = NUM_POS - 1; p >= 0; p--) begin
            if (BPOS_W'(p) >= r_pos && digit_len(r_digits[p]) != '0) begin
                found = 1'b1;
                sel = POS_W'(p);
            end
        end
        sel_digit = r_digits[sel];
        sel_len = digit_len(sel_digit);
    end

    always_comb begin
        adv = !r_out_valid || pop;
        n_busy = r_busy;
        n_digits = r_digits;
        n_pos = r_pos;
        n_idx = r_idx;
        n_out_valid = r_out_valid && !pop;
        n_char = r_char;
        n_last = r_last;
        o_q_rd = 1'b0;
        if (!r_busy) begin
            if (!i_q_empty) begin
                o_q_rd = 1'b1;
                n_busy = 1'b1;
                n_digits = i_q_data;
                n_pos = '0;
                n_idx = '0;
            end
        end else if (adv) begin
            n_out_valid = 1'b1;
            if (found) begin
                n_char = sym_char(sel, digit_sym(sel_digit, r_idx));
                n_last = 1'b0;
                if (LEN_W'(r_idx) + 1'b1 == sel_len) begin
                    n_pos = BPOS_W'(sel) + 1'b1;
                    n_idx = '0;
                end else begin
                    n_pos = BPOS_W'(sel);
                    n_idx = r_idx + 1'b1;
                end
            end else begin
                n_char = CH_NL;
                n_last = 1'b1;
                n_busy = 1'b0;
            end
        end
    end

    assign empty = !r_out_valid;
    assign o_char_code = r_char;
    assign o_last = r_last;

    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_char == CH_NL)
        else $error("closing mark without newline code");

    a_newline_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_last |-> r_char != CH_NL)
        else $error("newline code on a letter");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pos <= BPOS_W'(NUM_POS))
        else $error("digit position out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && adv && !found |=> !r_busy)
        else $error("back end still busy after closing newline");

endmodule

FILE: design/roman_numeral_encoder_top.sv
// Top level of the Roman numeral encoder.
//
// Input channel: an integer is transferred on i_value when push is high and
// full is low. Values above 3999 are clamped to 3999.
// Result channel: one ASCII character per transfer, when pop is high and empty
// is low. Each run is the numeral's letters followed by a newline with
// o_last high; zero gives the newline alone.
// The front end accepts a value, splits it into four decimal digits (one
// digit per cycle) and then writes the queue, waiting while it is full.
// The back end loads a value from the queue and then emits one character
// per cycle while the receiver keeps taking them.
// With an idle back end, the first character is registered after the split,
// the queue write and the back-end load.
// A two-entry queue between the halves lets the front end split the next
// value while the back end is still emitting the current one.
// When the receiver stalls, the character register holds and the back end
// waits; the queue then fills and full stays high. A synchronous reset clears
// the queue, the front end state and the back end's busy and output valid flags.
module roman_numeral_encoder_top import rne_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] i_value,
    output logic               empty,
    input  logic               pop,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic               o_last
);

    logic    q_wr;
    logic    q_full;
    t_digits q_wdata;
    logic    q_rd;
    logic    q_empty;
    t_digits q_rdata;

    rne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_value  (i_value),
        .o_q_wr   (q_wr),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    rne_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    rne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_rd      (q_rd),
        .empty       (empty),
        .pop         (pop),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

FILE: tb/tb_roman_numeral_encoder_top.sv
// Self-checking testbench for the Roman numeral encoder top level.
`timescale 1ns / 1ps

module tb_roman_numeral_encoder_top;
    import rne_pkg::*;

    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 40;
    localparam int MARK_COUNT = 13;
    localparam int MAX_LETTERS = 15;
    localparam logic [CHAR_W-1:0] NO_TAIL = 8'h00;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 settle;
    } t_number;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_glyph;

    typedef struct {
        int unsigned       weight;
        logic [CHAR_W-1:0] head;
        logic [CHAR_W-1:0] tail;
    } t_mark;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [VALUE_W-1:0] i_value = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last;

    t_number numbers_to_send[$];
    t_glyph  pending_glyphs[$];
    int      numbers_taken = 0;
    int      numbers_noted = 0;
    int      glyphs_taken = 0;
    int      glyphs_noted = 0;
    int      send_pause = 0;
    int      send_calm = 0;
    int      take_pause = 0;
    int      take_calm = 0;
    int      mismatches = 0;
    int      cycles = 0;

    roman_numeral_encoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_value    (i_value),
        .empty      (empty),
        .pop        (pop),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_mark roman_mark(input int k);
        t_mark m;
        case (k)
            0:  m = '{1000, CH_M, NO_TAIL};
            1:  m = '{900,  CH_C, CH_M};
            2:  m = '{500,  CH_D, NO_TAIL};
            3:  m = '{400,  CH_C, CH_D};
            4:  m = '{100,  CH_C, NO_TAIL};
            5:  m = '{90,   CH_X, CH_C};
            6:  m = '{50,   CH_L, NO_TAIL};
            7:  m = '{40,   CH_X, CH_L};
            8:  m = '{10,   CH_X, NO_TAIL};
            9:  m = '{9,    CH_I, CH_X};
            10: m = '{5,    CH_V, NO_TAIL};
            11: m = '{4,    CH_I, CH_V};
            default: m = '{1, CH_I, NO_TAIL};
        endcase
        return m;
    endfunction

    function automatic void spell_roman(input logic [VALUE_W-1:0] value);
        int unsigned rest;
        int          letters;
        t_mark       m;
        rest = value;
        letters = 0;
        if (rest > VALUE_LIMIT) begin
            rest = VALUE_LIMIT;
        end
        for (int k = 0; k < MARK_COUNT; k++) begin
            m = roman_mark(k);
            while (rest >= m.weight && letters < MAX_LETTERS) begin
                pending_glyphs.push_back('{m.head, 1'b0});
                letters++;
                if (m.tail != NO_TAIL && letters < MAX_LETTERS) begin
                    pending_glyphs.push_back('{m.tail, 1'b0});
                    letters++;
                end
                rest -= m.weight;
            end
        end
        pending_glyphs.push_back('{CH_NL, 1'b1});
    endfunction

    // Mostly short pauses, a few long ones, and now and then a calm stretch.
    function automatic int pick_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return VALUE_W'($urandom_range(0, 3999));
        end
        if (r < 77) begin
            return VALUE_W'($urandom_range(0, 30));
        end
        if (r < 87) begin
            return VALUE_W'($urandom_range(4000, 4095));
        end
        return VALUE_W'($urandom);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("roman_numeral_encoder_top: mismatch");
            $finish;
        end
    end

    // Checks each result transfer and predicts each input transfer.
    always @(posedge i_clk) begin
        t_glyph want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                glyphs_taken++;
                if (pending_glyphs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: char 0x%02h last %0b",
                                 o_char_code, o_last);
                    end
                end else begin
                    want = pending_glyphs.pop_front();
                    if (o_char_code !== want.code || o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: char 0x%02h last %0b, expected 0x%02h last %0b",
                                     o_char_code, o_last, want.code, want.last);
                        end
                    end
                end
            end
            if (push && !full) begin
                spell_roman(i_value);
                void'(numbers_to_send.pop_front());
                numbers_taken++;
            end
        end
    end

    always @(negedge i_clk) begin
        bit drive;
        drive = 1'b0;
        if (i_rst_n) begin
            if (numbers_taken != numbers_noted) begin
                numbers_noted = numbers_taken;
                send_pause = pick_pause(send_calm);
            end
            if (send_pause > 0) begin
                send_pause--;
            end else if (numbers_to_send.size() != 0) begin
                drive = !(numbers_to_send[0].settle && pending_glyphs.size() != 0);
            end
        end
        push <= drive;
        if (drive) begin
            i_value <= numbers_to_send[0].value;
        end
    end

    always @(negedge i_clk) begin
        bit ready;
        ready = 1'b0;
        if (i_rst_n) begin
            if (glyphs_taken != glyphs_noted) begin
                glyphs_noted = glyphs_taken;
                take_pause = pick_pause(take_calm);
            end
            if (take_pause > 0) begin
                take_pause--;
            end else begin
                ready = 1'b1;
            end
        end
        pop <= ready;
    end

    initial begin
        logic [VALUE_W-1:0] directed[$];
        directed = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd9, 12'd10, 12'd14, 12'd40,
                     12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900,
                     12'd999, 12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd4000,
                     12'd4095, 12'h555, 12'hAAA};
        foreach (directed[i]) begin
            numbers_to_send.push_back('{directed[i], 1'b0});
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            numbers_to_send.push_back('{random_value(), i == 0 || $urandom_range(0, 59) == 0});
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (numbers_to_send.size() != 0 || pending_glyphs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_glyphs.size() == 0) begin
            $display("roman_numeral_encoder_top: match");
        end else begin
            $display("roman_numeral_encoder_top: mismatch");
        end
        $finish;
    end

endmodule
